// ----- rtl/display_list_fixup_scanner_core_defines.svh -----
// Assertion macros used by the checker file.
`ifndef DISPLAY_LIST_FIXUP_SCANNER_CORE_DEFINES_SVH
`define DISPLAY_LIST_FIXUP_SCANNER_CORE_DEFINES_SVH

// Same-cycle implication.
`define DLFS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dlfs assertion failed");

// Next-cycle implication.
`define DLFS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dlfs assertion failed");

`endif

// ----- rtl/dlfs_pkg.sv -----
`timescale 1ns / 1ps
package dlfs_pkg;

    localparam logic [7:0] OP_VERTEX     = 8'h01;
    localparam logic [7:0] OP_SET_IMAGE  = 8'hFD;
    localparam logic [7:0] OP_LOAD_BLOCK = 8'hF3;
    localparam logic [7:0] OP_LOAD_PAL   = 8'hF0;
    localparam logic [7:0] OWN_SEGMENT   = 8'h0E;

    localparam logic [1:0] SIZE_4B  = 2'd0;
    localparam logic [1:0] SIZE_8B  = 2'd1;
    localparam logic [1:0] SIZE_16B = 2'd2;
    localparam logic [1:0] SIZE_32B = 2'd3;

    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_BYTES  = 2'd1;
    localparam logic [1:0] KIND_HALVES = 2'd2;

    localparam int OFFSET_W = 24;
    localparam int LEN_W    = 14;
    localparam int BLOB_W   = 25;
    localparam logic [BLOB_W-1:0] BLOB_RESET = 25'h100_0000;

    typedef struct packed {
        logic                fit_only;
        logic [OFFSET_W-1:0] offset;
        logic [LEN_W-1:0]    len;
        logic [1:0]          kind;
    } job_t;

endpackage

// ----- rtl/display_list_fixup_scanner_core.sv -----
`timescale 1ns / 1ps
// Display-list fixup scanner.
// Input queue side: one 64-bit command per beat on command_high/command_low with
// start_of_blob, taken at a clock edge where push is high and full is low.
// Result queue side: while empty is low, region_offset/region_bytes/fixup_kind
// show the oldest region; it leaves at an edge where pop is high.
// A command yields zero or one region; commands without a region leave no trace
// on the result side.
// Write blob_bytes via blob_bytes_wr only while idle; the block does not enforce this.
// Decode writes the two-entry job queue at the edge that takes a command beat;
// the bounds stage then registers the region from the queue head.
// Throughput: one command per cycle, sustained while pop keeps up.
// When pop stalls, the bounds stage holds its result, the job queue fills, and
// full rises once two jobs are waiting behind it; region-free commands are
// still refused then.
// Reset clears the pending texture, empties both queues and sets blob_bytes to
// 16777216.
module display_list_fixup_scanner_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        start_of_blob,
    input  logic [31:0] command_high,
    input  logic [31:0] command_low,
    output logic        empty,
    input  logic        pop,
    output logic [23:0] region_offset,
    output logic [13:0] region_bytes,
    output logic [1:0]  fixup_kind,
    input  logic        blob_bytes_wr,
    input  logic [24:0] blob_bytes
);

    logic           accept;
    logic           job_push;
    dlfs_pkg::job_t job;
    logic           q_valid;
    logic           q_full;
    dlfs_pkg::job_t q_data;
    logic           take;

    assign full   = q_full;
    assign accept = push && !q_full;

    dlfs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .start_of_blob (start_of_blob),
        .command_high  (command_high),
        .command_low   (command_low),
        .job_push      (job_push),
        .job           (job)
    );

    dlfs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job),
        .take      (take),
        .q_valid   (q_valid),
        .q_full    (q_full),
        .q_data    (q_data)
    );

    dlfs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .blob_bytes_wr (blob_bytes_wr),
        .blob_bytes    (blob_bytes),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .take          (take),
        .empty         (empty),
        .pop           (pop),
        .region_offset (region_offset),
        .region_bytes  (region_bytes),
        .fixup_kind    (fixup_kind)
    );

endmodule

// ----- rtl/dlfs_front.sv -----
`timescale 1ns / 1ps
module dlfs_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 start_of_blob,
    input  logic [31:0]          command_high,
    input  logic [31:0]          command_low,
    output logic                 job_push,
    output dlfs_pkg::job_t       job
);

    logic                          pending_valid_reg, pending_valid_next;
    logic [dlfs_pkg::OFFSET_W-1:0] pending_offset_reg, pending_offset_next;
    logic [1:0]                    pending_size_reg, pending_size_next;

    logic [7:0]  op;
    logic [7:0]  seg;
    logic        pv_eff;
    logic [7:0]  count;
    logic [12:0] texels;
    logic [13:0] tex_span;
    logic [14:0] tex_round;
    logic [10:0] entries;
    logic [12:0] pal_round;
    logic        emit;

    always_comb
    begin
        op        = command_high[31:24];
        seg       = command_low[31:24];
        pv_eff    = pending_valid_reg & ~start_of_blob;
        count     = command_high[19:12];
        texels    = {1'b0, command_low[23:12]} + 13'd1;
        tex_span  = {1'b0, texels};
        case (pending_size_reg)
            dlfs_pkg::SIZE_4B:  tex_span = {2'b00, 12'((texels + 13'd1) >> 1)};
            dlfs_pkg::SIZE_8B:  tex_span = {1'b0, texels};
            default:            tex_span = {texels, 1'b0};
        endcase
        tex_round = ({1'b0, tex_span} + 15'd3) & ~15'd3;
        entries   = {1'b0, command_low[23:14]} + 11'd1;
        pal_round = ({1'b0, entries, 1'b0} + 13'd3) & ~13'd3;

        pending_valid_next  = pv_eff;
        pending_offset_next = pending_offset_reg;
        pending_size_next   = pending_size_reg;
        emit                = 1'b0;
        job.fit_only        = 1'b0;
        job.offset          = pending_offset_reg;
        job.len             = tex_round[13:0];
        job.kind            = dlfs_pkg::KIND_BYTES;

        unique case (op)
            dlfs_pkg::OP_VERTEX:
            begin
                job.fit_only = 1'b1;
                job.offset   = command_low[23:0];
                job.len      = {2'b00, count, 4'b0000};
                job.kind     = dlfs_pkg::KIND_VERTEX;
                emit         = (seg == dlfs_pkg::OWN_SEGMENT) && (count != 8'd0);
            end
            dlfs_pkg::OP_SET_IMAGE:
            begin
                if (seg == dlfs_pkg::OWN_SEGMENT)
                begin
                    pending_valid_next  = 1'b1;
                    pending_offset_next = command_low[23:0];
                    pending_size_next   = command_high[20:19];
                end
                else
                begin
                    pending_valid_next = 1'b0;
                end
            end
            dlfs_pkg::OP_LOAD_BLOCK:
            begin
                pending_valid_next = 1'b0;
                emit     = pv_eff && (pending_size_reg != dlfs_pkg::SIZE_32B);
                job.kind = (pending_size_reg == dlfs_pkg::SIZE_16B) ?
                           dlfs_pkg::KIND_HALVES : dlfs_pkg::KIND_BYTES;
            end
            dlfs_pkg::OP_LOAD_PAL:
            begin
                pending_valid_next = 1'b0;
                emit     = pv_eff;
                job.len  = {1'b0, pal_round};
                job.kind = dlfs_pkg::KIND_HALVES;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        job_push = accept && emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_valid_reg  <= 1'b0;
            pending_offset_reg <= '0;
            pending_size_reg   <= dlfs_pkg::SIZE_4B;
        end
        else if (accept)
        begin
            pending_valid_reg  <= pending_valid_next;
            pending_offset_reg <= pending_offset_next;
            pending_size_reg   <= pending_size_next;
        end
    end

endmodule

// ----- rtl/dlfs_queue.sv -----
`timescale 1ns / 1ps
module dlfs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dlfs_pkg::job_t push_data,
    input  logic           take,
    output logic           q_valid,
    output logic           q_full,
    output dlfs_pkg::job_t q_data
);

    dlfs_pkg::job_t entries_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    always_comb
    begin
        q_valid     = (count_reg != 2'd0);
        q_full      = (count_reg == 2'd2);
        q_data      = entries_reg[rd_ptr_reg];
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/dlfs_back.sv -----
`timescale 1ns / 1ps
module dlfs_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          blob_bytes_wr,
    input  logic [dlfs_pkg::BLOB_W-1:0]   blob_bytes,
    input  logic                          q_valid,
    input  dlfs_pkg::job_t                q_data,
    output logic                          take,
    output logic                          empty,
    input  logic                          pop,
    output logic [dlfs_pkg::OFFSET_W-1:0] region_offset,
    output logic [dlfs_pkg::LEN_W-1:0]    region_bytes,
    output logic [1:0]                    fixup_kind
);

    logic [dlfs_pkg::BLOB_W-1:0]   blob_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [dlfs_pkg::OFFSET_W-1:0] offset_reg;
    logic [dlfs_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [1:0]                    kind_reg;
    logic [dlfs_pkg::BLOB_W-1:0]   end_pos;
    logic [dlfs_pkg::BLOB_W-1:0]   room;
    logic                          emit;

    always_comb
    begin
        take    = q_valid && (!out_valid_reg || pop);
        end_pos = {1'b0, q_data.offset} + {11'd0, q_data.len};
        room    = blob_reg - {1'b0, q_data.offset};
        len_next = q_data.len;
        if (q_data.fit_only)
        begin
            emit = (end_pos <= blob_reg);
        end
        else
        begin
            emit = ({1'b0, q_data.offset} <= blob_reg);
            if (end_pos > blob_reg)
            begin
                len_next = room[dlfs_pkg::LEN_W-1:0];
            end
        end
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = emit;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        empty         = !out_valid_reg;
        region_offset = offset_reg;
        region_bytes  = len_reg;
        fixup_kind    = kind_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blob_reg      <= dlfs_pkg::BLOB_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (blob_bytes_wr)
            begin
                blob_reg <= blob_bytes;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            offset_reg <= q_data.offset;
            len_reg    <= len_next;
            kind_reg   <= q_data.kind;
        end
    end

endmodule

// ----- rtl/dlfs_checker.sv -----
`timescale 1ns / 1ps
`include "display_list_fixup_scanner_core_defines.svh"
module dlfs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [23:0] region_offset,
    input logic [13:0] region_bytes,
    input logic [1:0]  fixup_kind
);

    `DLFS_ASSERT_NXT(a_hold, clk, rst_n, !empty && !pop,
        !empty && $stable(region_offset) && $stable(region_bytes) && $stable(fixup_kind))
    `DLFS_ASSERT_IMP(a_kind, clk, rst_n, !empty, fixup_kind <= dlfs_pkg::KIND_HALVES)
    `DLFS_ASSERT_IMP(a_len, clk, rst_n, !empty, region_bytes <= 14'd8192)
    `DLFS_ASSERT_IMP(a_vtx, clk, rst_n, !empty && fixup_kind == dlfs_pkg::KIND_VERTEX,
        region_bytes != 14'd0 && region_bytes[3:0] == 4'd0 && region_bytes <= 14'd4080)

endmodule

bind display_list_fixup_scanner_core dlfs_checker u_dlfs_checker (.*);
